// ===== hdl/smt_pkg.sv =====
// Package for the sorted multiset table: sizes, entry type, codes and saturation helpers.
// Depends on nothing; used by smt_entry_ram and sorted_multiset_table.
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

  localparam int CAPACITY    = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W       = $clog2(CAPACITY + 1);

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  localparam logic [1:0] KIND_INSERT     = 2'd0;
  localparam logic [1:0] KIND_REMOVE_ALL = 2'd1;
  localparam logic [1:0] KIND_REMOVE_ONE = 2'd2;

  typedef enum logic [2:0] {
    STATUS_NEW     = 3'd0,
    STATUS_ADDED   = 3'd1,
    STATUS_REMOVED = 3'd2,
    STATUS_DECR    = 3'd3,
    STATUS_ABSENT  = 3'd4,
    STATUS_FULL    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_SHUP,
    ST_SHDN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0]     key;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [4:0] sat5(input logic [31:0] v);
    sat5 = (v > 32'd31) ? 5'd31 : v[4:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smt_entry_ram.sv =====
// Entry memory of the sorted multiset table: one write port, one registered read port.
// Depends on smt_pkg for the entry type and address width.
`timescale 1ns / 1ps
`default_nettype none

module smt_entry_ram (
  input  wire                        clk,
  input  wire                        we,
  input  wire [smt_pkg::ADDR_W-1:0]  waddr,
  input  smt_pkg::entry_t            wdata,
  input  wire [smt_pkg::ADDR_W-1:0]  raddr,
  output smt_pkg::entry_t            rdata
);

  smt_pkg::entry_t mem [smt_pkg::CAPACITY];
  smt_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/sorted_multiset_table.sv =====
// Top level of the sorted multiset table: request sequencer around the entry memory.
// Depends on smt_pkg and smt_entry_ram.
//
// Usage: a request item enters on the in_ stream (kind in in_tuser, value and add_count in
// in_tdata); one result item leaves on the out_ stream (status in out_tuser, count_after and
// entries_held in out_tdata). Requests are handled one at a time. Each one scans the table
// from the lowest key through the single memory read port, one entry per cycle, until it
// meets a key not below the requested value; an insert of a new value or a deletion then
// moves the entries above that point by one place, again one entry per cycle. The next
// request is accepted once the result is registered in the output register, which then
// holds it, so the next request is accepted while it waits. A stalled receiver holds that
// register; a request finished behind it waits until the register is taken. Reset empties
// the table at once (no clearing pass) and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module sorted_multiset_table (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [47:0] in_tdata,   // value [31:0], add_count [47:32]
  input  wire [1:0]  in_tuser,   // kind [1:0]
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [23:0] out_tdata, // count_after [15:0], entries_held [20:16], zero [23:21]
  output logic [2:0]  out_tuser  // status [2:0]
);

  localparam int AW = smt_pkg::ADDR_W;
  localparam int OW = smt_pkg::OCC_W;
  localparam int CW = smt_pkg::COUNT_WIDTH;

  smt_pkg::state_t state_r, state_nxt;

  logic [1:0]         kind_r, kind_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [15:0]        add_r, add_nxt;

  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] idx_r, idx_nxt;
  logic          rdv_r, rdv_nxt;
  logic [OW-1:0] rd_idx_r, rd_idx_nxt;
  logic [OW-1:0] pos_r, pos_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic [OW-1:0] ptr_r, ptr_nxt;
  logic          wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;

  smt_pkg::status_t res_status_r, res_status_nxt;
  logic [CW-1:0]    res_cnt_r, res_cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  smt_pkg::status_t out_status_r, out_status_nxt;
  logic [15:0]      out_count_r, out_count_nxt;
  logic [4:0]       out_held_r, out_held_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  smt_pkg::entry_t ram_wdata;
  logic [AW-1:0]   ram_raddr;
  smt_pkg::entry_t ram_rdata;

  logic [32:0]   add_sat;
  logic [32:0]   sum;
  logic [CW-1:0] sum_sat;

  smt_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign add_sat = (33'(add_r) > smt_pkg::COUNT_MAX) ? smt_pkg::COUNT_MAX : 33'(add_r);
  assign sum     = 33'(fcnt_r) + add_sat;
  assign sum_sat = (sum > smt_pkg::COUNT_MAX) ? CW'(smt_pkg::COUNT_MAX) : CW'(sum);

  assign in_tready  = (state_r == smt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'd0, out_held_r, out_count_r};

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    value_nxt      = value_r;
    add_nxt        = add_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    rdv_nxt        = rdv_r;
    rd_idx_nxt     = rd_idx_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    fcnt_nxt       = fcnt_r;
    ptr_nxt        = ptr_r;
    wv_nxt         = wv_r;
    wa_nxt         = wa_r;
    res_status_nxt = res_status_r;
    res_cnt_nxt    = res_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_held_nxt   = out_held_r;
    ram_we         = 1'b0;
    ram_waddr      = wa_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = AW'(idx_r);

    unique case (state_r)
      smt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          value_nxt = in_tdata[31:0];
          add_nxt   = in_tdata[47:32];
          idx_nxt   = '0;
          rdv_nxt   = 1'b0;
          state_nxt = smt_pkg::ST_SCAN;
        end
      end

      smt_pkg::ST_SCAN: begin
        ram_raddr = AW'(idx_r);
        if (rdv_r && (ram_rdata.key >= value_r)) begin
          pos_nxt   = rd_idx_r;
          found_nxt = (ram_rdata.key == value_r);
          fcnt_nxt  = ram_rdata.count;
          rdv_nxt   = 1'b0;
          state_nxt = smt_pkg::ST_ACT;
        end else if (idx_r == occ_r) begin
          if (rdv_r) begin
            rdv_nxt = 1'b0;
          end else begin
            pos_nxt   = occ_r;
            found_nxt = 1'b0;
            state_nxt = smt_pkg::ST_ACT;
          end
        end else begin
          rdv_nxt    = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + OW'(1);
        end
      end

      smt_pkg::ST_ACT: begin
        res_cnt_nxt    = '0;
        res_status_nxt = smt_pkg::STATUS_ABSENT;
        state_nxt      = smt_pkg::ST_DONE;
        wv_nxt         = 1'b0;
        case (kind_r)
          smt_pkg::KIND_INSERT: begin
            if (found_r) begin
              ram_we         = 1'b1;
              ram_waddr      = AW'(pos_r);
              ram_wdata.key  = value_r;
              ram_wdata.count = sum_sat;
              res_cnt_nxt    = sum_sat;
              res_status_nxt = smt_pkg::STATUS_ADDED;
            end else if (occ_r == OW'(smt_pkg::CAPACITY)) begin
              res_status_nxt = smt_pkg::STATUS_FULL;
            end else begin
              res_cnt_nxt    = CW'(add_sat);
              res_status_nxt = smt_pkg::STATUS_NEW;
              ptr_nxt        = occ_r;
              state_nxt      = smt_pkg::ST_SHUP;
            end
          end
          smt_pkg::KIND_REMOVE_ALL: begin
            if (found_r) begin
              res_status_nxt = smt_pkg::STATUS_REMOVED;
              ptr_nxt        = pos_r + OW'(1);
              state_nxt      = smt_pkg::ST_SHDN;
            end
          end
          smt_pkg::KIND_REMOVE_ONE: begin
            if (found_r) begin
              if (fcnt_r > CW'(1)) begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(pos_r);
                ram_wdata.key   = value_r;
                ram_wdata.count = fcnt_r - CW'(1);
                res_cnt_nxt     = fcnt_r - CW'(1);
                res_status_nxt  = smt_pkg::STATUS_DECR;
              end else begin
                res_status_nxt = smt_pkg::STATUS_REMOVED;
                ptr_nxt        = pos_r + OW'(1);
                state_nxt      = smt_pkg::ST_SHDN;
              end
            end
          end
          default: begin
          end
        endcase
      end

      smt_pkg::ST_SHUP: begin
        ram_raddr = AW'(ptr_r - OW'(1));
        if (wv_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (ptr_r > pos_r) begin
          wv_nxt  = 1'b1;
          wa_nxt  = AW'(ptr_r);
          ptr_nxt = ptr_r - OW'(1);
        end else if (wv_r) begin
          wv_nxt = 1'b0;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = AW'(pos_r);
          ram_wdata.key   = value_r;
          ram_wdata.count = CW'(add_sat);
          occ_nxt         = occ_r + OW'(1);
          state_nxt       = smt_pkg::ST_DONE;
        end
      end

      smt_pkg::ST_SHDN: begin
        ram_raddr = AW'(ptr_r);
        if (wv_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (ptr_r < occ_r) begin
          wv_nxt  = 1'b1;
          wa_nxt  = AW'(ptr_r - OW'(1));
          ptr_nxt = ptr_r + OW'(1);
        end else if (wv_r) begin
          wv_nxt = 1'b0;
        end else begin
          occ_nxt   = occ_r - OW'(1);
          state_nxt = smt_pkg::ST_DONE;
        end
      end

      smt_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = smt_pkg::sat16(32'(res_cnt_r));
          out_held_nxt   = smt_pkg::sat5(32'(occ_r));
          state_nxt      = smt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = smt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smt_pkg::ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      wv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= rdv_nxt;
      wv_r        <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    value_r      <= value_nxt;
    add_r        <= add_nxt;
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    fcnt_r       <= fcnt_nxt;
    ptr_r        <= ptr_nxt;
    wa_r         <= wa_nxt;
    res_status_r <= res_status_nxt;
    res_cnt_r    <= res_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_held_r   <= out_held_nxt;
  end

endmodule

`default_nettype wire
